FILE: rtl/core/gms_pkg.sv
// Shared types, constants and a helper function for the grid majority smoothing unit.
// No dependencies; used by gms_raster_ctrl, gms_window and grid_majority_smoothing_unit.
`default_nettype none

package gms_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_GRID_WIDTH      = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT     = 2'd1;
    localparam logic [1:0] CFG_FLOOR_THRESHOLD = 2'd2;

    localparam logic [7:0] GRID_WIDTH_RST      = 8'd100;
    localparam logic [7:0] GRID_HEIGHT_RST     = 8'd100;
    localparam logic [3:0] FLOOR_THRESHOLD_RST = 4'd4;

    localparam logic [7:0] GRID_MIN   = 8'd3;
    localparam logic [7:0] MAX_HEIGHT = 8'd128;
    localparam logic [3:0] WIN_CELLS  = 4'd9;

    // position tag of a beat, carried from the raster counters to the output
    typedef struct packed {
        logic       emit;
        logic       last;
        logic [6:0] row;
        logic [6:0] col;
    } gms_tag_t;

    function automatic logic [3:0] count_ones9(input logic [8:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 9; i++)
        begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gms_line_mem.sv
// Two-row line store: one entry per column holding {upper, middle} cells.
// Synchronous write, registered read. Uses no package items.
`default_nettype none

module gms_line_mem #(
    parameter int MAX_WIDTH = 128
) (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output logic      [1:0]                   rd_data,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  wire logic [1:0]                   wr_data
);

    logic [1:0] mem [MAX_WIDTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/gms_raster_ctrl.sv
// Raster position counters: wraps column and row against the clamped grid
// size and tags each beat. Depends on gms_pkg.
`default_nettype none

module gms_raster_ctrl #(
    parameter int MAX_WIDTH = 128
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic [7:0]                   grid_width,
    input  wire logic [7:0]                   grid_height,
    output logic      [$clog2(MAX_WIDTH)-1:0] addr,
    output gms_pkg::gms_tag_t                 tag
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = ($clog2(MAX_WIDTH + 1) > 8) ? $clog2(MAX_WIDTH + 1) : 8;
    localparam int OCW   = (COL_W > 7) ? COL_W : 7;

    logic [COL_W-1:0] col_reg, col_next;
    logic [6:0]       row_reg, row_next;

    logic [WW-1:0] w, gw, col_a, col_n;
    logic [7:0]    h, row_a, row_n;
    logic [OCW-1:0] col_m1;

    // clamp grid size
    always_comb
    begin
        gw = WW'(grid_width);
        if (gw < WW'(gms_pkg::GRID_MIN))
            w = WW'(gms_pkg::GRID_MIN);
        else if (gw > WW'(MAX_WIDTH))
            w = WW'(MAX_WIDTH);
        else
            w = gw;
        if (grid_height < gms_pkg::GRID_MIN)
            h = gms_pkg::GRID_MIN;
        else if (grid_height > gms_pkg::MAX_HEIGHT)
            h = gms_pkg::MAX_HEIGHT;
        else
            h = grid_height;
    end

    // position of the arriving cell; wraps if the size shrank mid-grid
    always_comb
    begin
        col_a = WW'(col_reg);
        row_a = {1'b0, row_reg};
        if (col_a >= w)
        begin
            col_a = '0;
            row_a = row_a + 8'd1;
        end
        if (row_a >= h)
        begin
            row_a = 8'd0;
        end
        col_n = col_a + WW'(1);
        row_n = row_a;
        if (col_n >= w)
        begin
            col_n = '0;
            row_n = row_a + 8'd1;
            if (row_n >= h)
            begin
                row_n = 8'd0;
            end
        end
        col_next = COL_W'(col_n);
        row_next = row_n[6:0];
    end

    assign col_m1 = OCW'(col_a) - OCW'(1);

    always_comb
    begin
        addr     = COL_W'(col_a);
        tag.emit = (row_a >= 8'd2) && (col_a >= WW'(2));
        tag.last = (row_a == h - 8'd1) && (col_a == w - WW'(1));
        tag.row  = row_a[6:0] - 7'd1;
        tag.col  = col_m1[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/gms_window.sv
// 3x3 window: keeps the two previous columns, counts floor cells and
// applies the threshold. Depends on gms_pkg.
`default_nettype none

module gms_window (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift,
    input  wire logic [1:0] upper_mid,
    input  wire logic       lower_cell,
    input  wire logic [3:0] floor_threshold,
    output logic            wall
);

    logic [5:0] window_reg;
    logic [8:0] win;
    logic [3:0] floors;

    // column bits are {upper, middle, lower}; oldest column highest
    assign win    = {window_reg, upper_mid, lower_cell};
    assign floors = gms_pkg::WIN_CELLS - gms_pkg::count_ones9(win);
    assign wall   = !(floors > floor_threshold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (shift)
        begin
            window_reg <= win[5:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/grid_majority_smoothing_unit.sv
// Grid majority smoothing unit: one generation of 3x3 cave smoothing.
// Depends on gms_pkg, gms_line_mem, gms_raster_ctrl and gms_window.
//
// Input channel (in_valid/in_ready, cell_in): one cell per beat in raster
// order, 0 floor, 1 wall. Output channel (out_valid/out_ready): one beat
// per interior cell with cell_out, out_row, out_col and last_cell on the
// final interior cell. Border cells produce no beat.
// Configuration: cfg_write with cfg_index (0 width, 1 height, 2 threshold)
// and cfg_data; write only while the unit is idle.
// An accepted cell passes the window stage register, then the output register.
// Throughput: one cell per cycle unless stalled; the line store is read in the
// accept cycle and written back when the window stage commits.
// Stall: a held output register stalls the window stage only when that
// stage holds a result; in_ready then drops until out_ready returns.
// Reset: counters, window and configuration (100 x 100, threshold 4) are
// restored; the line store is not cleared and is filled by the first rows.
`default_nettype none

module grid_majority_smoothing_unit #(
    parameter int MAX_WIDTH = 128
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       cell_in,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            cell_out,
    output logic      [6:0] out_row,
    output logic      [6:0] out_col,
    output logic            last_cell
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [7:0] grid_width_reg;
    logic [7:0] grid_height_reg;
    logic [3:0] floor_threshold_reg;

    logic              accept, can_move, commit, wall;
    logic [COL_W-1:0]  rd_addr;
    logic [1:0]        rd_data;
    gms_pkg::gms_tag_t tag;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_cell_reg;
    logic [COL_W-1:0]  s1_addr_reg;
    gms_pkg::gms_tag_t s1_tag_reg;

    logic       out_valid_reg, out_valid_next;
    logic       cell_out_reg;
    logic [6:0] out_row_reg, out_col_reg;
    logic       last_cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg      <= gms_pkg::GRID_WIDTH_RST;
            grid_height_reg     <= gms_pkg::GRID_HEIGHT_RST;
            floor_threshold_reg <= gms_pkg::FLOOR_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gms_pkg::CFG_GRID_WIDTH:      grid_width_reg      <= cfg_data;
                gms_pkg::CFG_GRID_HEIGHT:     grid_height_reg     <= cfg_data;
                gms_pkg::CFG_FLOOR_THRESHOLD: floor_threshold_reg <= cfg_data[3:0];
                default:                      ;
            endcase
        end
    end

    // window stage moves on unless its result has nowhere to go
    assign can_move = !s1_valid_reg || !s1_tag_reg.emit || !out_valid_reg || out_ready;
    assign commit   = s1_valid_reg && can_move;
    assign in_ready = can_move;
    assign accept   = in_valid && in_ready;

    gms_raster_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_raster (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .addr        (rd_addr),
        .tag         (tag)
    );

    gms_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (commit),
        .wr_addr (s1_addr_reg),
        .wr_data ({rd_data[0], s1_cell_reg})
    );

    gms_window u_window (
        .clk             (clk),
        .rst_n           (rst_n),
        .shift           (commit),
        .upper_mid       (rd_data),
        .lower_cell      (s1_cell_reg),
        .floor_threshold (floor_threshold_reg),
        .wall            (wall)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (commit)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit && s1_tag_reg.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cell_reg <= cell_in;
            s1_addr_reg <= rd_addr;
            s1_tag_reg  <= tag;
        end
        if (commit && s1_tag_reg.emit)
        begin
            cell_out_reg  <= wall;
            out_row_reg   <= s1_tag_reg.row;
            out_col_reg   <= s1_tag_reg.col;
            last_cell_reg <= s1_tag_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign last_cell = last_cell_reg;

    // consecutive beats never touch the same line store entry
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && commit) |-> (rd_addr != s1_addr_reg))
        else $error("line store read and write hit the same column");

    // a held result in the window stage blocks new input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_tag_reg.emit && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while window stage is blocked");

    // every accepted beat occupies the window stage next cycle
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted beat lost before window stage");

    // an emitting commit always leaves a result in the output register
    a_commit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && s1_tag_reg.emit) |=> out_valid_reg)
        else $error("result dropped at output register");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Testbench for grid_majority_smoothing_unit: random and directed grids with a self-checking
// scoreboard that predicts every smoothed interior cell beat.
// Depends on gms_pkg and the RTL under rtl/core; self-contained otherwise.
`timescale 1ns / 100ps

module tb;

    class smoothing_scoreboard;
        localparam int unsigned LINE_LEN = 128;

        typedef struct packed {
            logic       wall;
            logic [6:0] row;
            logic [6:0] col;
            logic       last;
        } smoothed_cell_t;

        logic [7:0]     width_reg;
        logic [7:0]     height_reg;
        logic [3:0]     thresh_reg;
        bit             upper_line [LINE_LEN];
        bit             middle_line [LINE_LEN];
        bit [5:0]       window;
        int unsigned    col_pos;
        int unsigned    row_pos;
        smoothed_cell_t next_gen_q [$];
        int             errors;

        function new();
            width_reg  = gms_pkg::GRID_WIDTH_RST;
            height_reg = gms_pkg::GRID_HEIGHT_RST;
            thresh_reg = gms_pkg::FLOOR_THRESHOLD_RST;
            window     = '0;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
        endfunction

        function int unsigned fit(logic [7:0] v, int unsigned hi);
            if (v < gms_pkg::GRID_MIN)
                return gms_pkg::GRID_MIN;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned eff_width();
            return fit(width_reg, LINE_LEN);
        endfunction

        function int unsigned eff_height();
            return fit(height_reg, gms_pkg::MAX_HEIGHT);
        endfunction

        function bit at_origin();
            return (col_pos == 0) && (row_pos == 0);
        endfunction

        function int pending_count();
            return next_gen_q.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                gms_pkg::CFG_GRID_WIDTH:      width_reg = val;
                gms_pkg::CFG_GRID_HEIGHT:     height_reg = val;
                gms_pkg::CFG_FLOOR_THRESHOLD: thresh_reg = val[3:0];
                default: ;
            endcase
        endfunction

        // advance the raster position by one cell and queue the smoothed
        // cell of the window centre when it is interior
        function void smooth_cell(bit c);
            int unsigned    w;
            int unsigned    h;
            int unsigned    col;
            int unsigned    row;
            int unsigned    floors;
            bit [8:0]       win;
            smoothed_cell_t e;
            w   = eff_width();
            h   = eff_height();
            col = col_pos;
            row = row_pos;
            // counters left outside a shrunken grid wrap first
            if (col >= w)
            begin
                col = 0;
                row++;
            end
            if (row >= h)
                row = 0;
            win = {window, upper_line[col], middle_line[col], c};
            if (row >= 2 && col >= 2)
            begin
                floors = 9 - $countones(win);
                e.wall = (floors > thresh_reg) ? 1'b0 : 1'b1;
                e.row  = 7'(row - 1);
                e.col  = 7'(col - 1);
                e.last = (row == h - 1) && (col == w - 1);
                next_gen_q = {next_gen_q, e};
            end
            upper_line[col]  = middle_line[col];
            middle_line[col] = c;
            window = win[5:0];
            col++;
            if (col >= w)
            begin
                col = 0;
                row++;
                if (row >= h)
                    row = 0;
            end
            col_pos = col;
            row_pos = row;
        endfunction

        task report(string msg);
            errors++;
            $display("tb: mismatch: %s", msg);
        endtask

        task check_beat(logic c, logic [6:0] r, logic [6:0] k, logic l);
            smoothed_cell_t e;
            if (next_gen_q.size() == 0)
            begin
                report($sformatf("beat with nothing pending (row %0d col %0d)", r, k));
                return;
            end
            e = next_gen_q.pop_front();
            if (c !== e.wall)
                report($sformatf("cell_out r%0d c%0d: got %b want %b", e.row, e.col, c, e.wall));
            if (r !== e.row)
                report($sformatf("out_row: got %0d want %0d", r, e.row));
            if (k !== e.col)
                report($sformatf("out_col: got %0d want %0d", k, e.col));
            if (l !== e.last)
                report($sformatf("last_cell r%0d c%0d: got %b want %b", e.row, e.col, l, e.last));
        endtask
    endclass

    localparam int QUIET_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = gms_pkg::CFG_GRID_WIDTH;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       cell_in = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       cell_out;
    logic [6:0] out_row;
    logic [6:0] out_col;
    logic       last_cell;

    int         cells_sent = 0;
    int         quiet_cycles = 0;
    logic       no_idle;

    smoothing_scoreboard sb = new();

    // one stretch where neither side idles at random
    assign no_idle = (cells_sent >= 400) && (cells_sent < 700);

    always #6 clk = ~clk;

    grid_majority_smoothing_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cell_in   (cell_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cell_out  (cell_out),
        .out_row   (out_row),
        .out_col   (out_col),
        .last_cell (last_cell)
    );

    task automatic send_cell(input bit c);
        int gap;
        gap = 0;
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < 32)
                gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cell_in  <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.smooth_cell(c);
        cells_sent++;
    endtask

    // density: percent chance of a wall cell
    task automatic send_cells(input int n, input int density);
        repeat (n) send_cell($urandom_range(0, 99) < density);
    endtask

    task automatic finish_grid(input int density);
        do
            send_cell($urandom_range(0, 99) < density);
        while (!sb.at_origin());
    endtask

    // stop sending and wait until every pending beat is out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_grid(input logic [7:0] w, input logic [7:0] h, input logic [3:0] th);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= gms_pkg::CFG_GRID_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= gms_pkg::CFG_GRID_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= gms_pkg::CFG_FLOOR_THRESHOLD;
        cfg_data  <= {4'd0, th};
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(gms_pkg::CFG_GRID_WIDTH, w);
        sb.set_reg(gms_pkg::CFG_GRID_HEIGHT, h);
        sb.set_reg(gms_pkg::CFG_FLOOR_THRESHOLD, {4'd0, th});
    endtask

    // receiver: random stalls, plus a long hold-off every 150 beats
    initial
    begin
        int beats;
        bit hold;
        beats = 0;
        hold  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                sb.check_beat(cell_out, out_row, out_col, last_cell);
                beats++;
                hold = (beats % 150 == 0);
            end
            if (hold)
            begin
                out_ready <= 1'b0;
                repeat (90) @(posedge clk);
                hold = 1'b0;
            end
            out_ready <= no_idle || ($urandom_range(0, 99) >= 32);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int w;
        int h;
        int th;
        int dens;
        int mode;
        int phase;
        int rnd_start;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest grid, all walls, threshold 0
        program_grid(8'd3, 8'd3, 4'd0);
        finish_grid(100);
        // stop mid-grid past the new bounds: column and row both wrap,
        // then a floor-only grid with a threshold no count can exceed
        program_grid(8'd4, 8'd5, 4'd4);
        send_cells(11, 50);
        program_grid(8'd3, 8'd3, 4'd15);
        finish_grid(0);

        rnd_start = cells_sent;
        phase = 0;
        while (cells_sent - rnd_start < 710)
        begin
            th   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 6);
            dens = $urandom_range(15, 85);
            if (phase == 4)
            begin
                // widest grid, height clamped up
                program_grid(8'd255, 8'd0, 4'(th));
                finish_grid(dens);
            end
            else
            begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
                program_grid(8'(w), 8'(h), 4'(th));
                mode = $urandom_range(0, 99);
                if (mode < 25)
                begin
                    send_cells($urandom_range(1, sb.eff_width() * sb.eff_height() - 1), dens);
                    // only narrowing is safe mid-grid: wider columns may be unwritten
                    if (mode < 15)
                        program_grid(8'($urandom_range(0, sb.eff_width())),
                                     8'($urandom_range(0, 8)), 4'(th));
                    else
                        drain();
                end
                finish_grid(dens);
            end
            phase++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.pending_count() != 0)
            sb.report($sformatf("%0d cells never came out", sb.pending_count()));
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
